[design/ttfd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Thermal trend fan duty controller package
// Shared widths, reset values, register indexes and the settings bundle.
// ----------------------------------------------------------------------------
package ttfd_pkg;

   localparam int HISTORY_DEPTH = 2;
   localparam int FAN_COUNT     = 6;
   localparam int SENSOR_COUNT  = 5;

   localparam int TEMP_W     = 19;
   localparam int SUM_W      = 22;
   localparam int HIST_W     = 21;
   localparam int PEAK_W     = 18;
   localparam int BOUND_W    = 22;
   localparam int DUTY_W     = 7;
   localparam int MASK_W     = 6;
   localparam int CSR_DATA_W = 19;
   localparam int CSR_INDEX_W = 3;

   localparam int FAN_SCAN_W = (FAN_COUNT > MASK_W) ? FAN_COUNT : MASK_W;
   localparam logic [FAN_SCAN_W-1:0] FAN_SELECT = FAN_SCAN_W'((64'd1 << FAN_COUNT) - 64'd1);

   localparam int TREND_CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam logic [TREND_CNT_W-1:0] TREND_FIRM = TREND_CNT_W'((HISTORY_DEPTH + 1) / 2);

   localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};
   localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};

   localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

   localparam logic signed [TEMP_W-1:0] AVG_FULL_RESET  = 19'sd45000;
   localparam logic signed [TEMP_W-1:0] AVG_MID_RESET   = 19'sd40000;
   localparam logic signed [TEMP_W-1:0] AVG_LOW_RESET   = 19'sd35000;
   localparam logic [PEAK_W-1:0]        PEAK_FULL_RESET = 18'd50000;
   localparam logic [PEAK_W-1:0]        PEAK_MID_RESET  = 18'd45000;
   localparam logic [DUTY_W-1:0]        MID_DUTY_RESET  = 7'd63;
   localparam logic [DUTY_W-1:0]        LOW_DUTY_RESET  = 7'd32;
   localparam logic [DUTY_W-1:0]        BOOST_RESET     = 7'd13;
   localparam logic [DUTY_W-1:0]        HELD_DUTY_RESET = 7'd32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_AVG_FULL  = 3'd0,
      CSR_AVG_MID   = 3'd1,
      CSR_AVG_LOW   = 3'd2,
      CSR_PEAK_FULL = 3'd3,
      CSR_PEAK_MID  = 3'd4,
      CSR_MID_DUTY  = 3'd5,
      CSR_LOW_DUTY  = 3'd6,
      CSR_BOOST     = 3'd7
   } csr_index_type;

   // The average thresholds are kept as bounds on the saturated sum:
   // the truncated average reaches a threshold exactly when the sum
   // lies strictly above the stored bound.
   typedef struct packed {
      logic signed [BOUND_W-1:0] avg_full_bound;
      logic signed [BOUND_W-1:0] avg_mid_bound;
      logic signed [BOUND_W-1:0] avg_low_bound;
      logic [PEAK_W-1:0]         peak_full;
      logic [PEAK_W-1:0]         peak_mid;
      logic [DUTY_W-1:0]         mid_duty;
      logic [DUTY_W-1:0]         low_duty;
      logic [DUTY_W-1:0]         reverse_boost;
   } cfg_type;

endpackage
`default_nettype wire

[design/ttfd_csr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Settings registers
// Holds the thresholds, duty levels and boost; average thresholds are
// converted to sum bounds when written.
// ----------------------------------------------------------------------------
module ttfd_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [ttfd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [ttfd_pkg::CSR_DATA_W-1:0]       csr_data,
   output ttfd_pkg::cfg_type                          cfg
);

   ttfd_pkg::cfg_type cfg_ff;
   logic              write_en;

   function automatic logic signed [ttfd_pkg::BOUND_W-1:0] avg_bound(
      input logic signed [ttfd_pkg::TEMP_W-1:0] thr
   );
      logic signed [ttfd_pkg::BOUND_W-1:0] t_ext;
      logic signed [ttfd_pkg::BOUND_W-1:0] t_five;
      t_ext  = ttfd_pkg::BOUND_W'(thr);
      t_five = (t_ext <<< 2) + t_ext;
      if (thr > 0) begin
         avg_bound = t_five - ttfd_pkg::BOUND_W'(1);
      end else begin
         avg_bound = t_five - ttfd_pkg::BOUND_W'(5);
      end
   endfunction

   assign csr_ready = 1'b1;
   assign write_en  = csr_valid && csr_ready;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.avg_full_bound <= avg_bound(ttfd_pkg::AVG_FULL_RESET);
         cfg_ff.avg_mid_bound  <= avg_bound(ttfd_pkg::AVG_MID_RESET);
         cfg_ff.avg_low_bound  <= avg_bound(ttfd_pkg::AVG_LOW_RESET);
         cfg_ff.peak_full      <= ttfd_pkg::PEAK_FULL_RESET;
         cfg_ff.peak_mid       <= ttfd_pkg::PEAK_MID_RESET;
         cfg_ff.mid_duty       <= ttfd_pkg::MID_DUTY_RESET;
         cfg_ff.low_duty       <= ttfd_pkg::LOW_DUTY_RESET;
         cfg_ff.reverse_boost  <= ttfd_pkg::BOOST_RESET;
      end else if (write_en) begin
         case (ttfd_pkg::csr_index_type'(csr_index))
            ttfd_pkg::CSR_AVG_FULL: begin
               cfg_ff.avg_full_bound <= avg_bound(csr_data);
            end
            ttfd_pkg::CSR_AVG_MID: begin
               cfg_ff.avg_mid_bound <= avg_bound(csr_data);
            end
            ttfd_pkg::CSR_AVG_LOW: begin
               cfg_ff.avg_low_bound <= avg_bound(csr_data);
            end
            ttfd_pkg::CSR_PEAK_FULL: begin
               cfg_ff.peak_full <= csr_data[ttfd_pkg::PEAK_W-1:0];
            end
            ttfd_pkg::CSR_PEAK_MID: begin
               cfg_ff.peak_mid <= csr_data[ttfd_pkg::PEAK_W-1:0];
            end
            ttfd_pkg::CSR_MID_DUTY: begin
               cfg_ff.mid_duty <= csr_data[ttfd_pkg::DUTY_W-1:0];
            end
            ttfd_pkg::CSR_LOW_DUTY: begin
               cfg_ff.low_duty <= csr_data[ttfd_pkg::DUTY_W-1:0];
            end
            ttfd_pkg::CSR_BOOST: begin
               cfg_ff.reverse_boost <= csr_data[ttfd_pkg::DUTY_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

[design/ttfd_trend.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Trend history
// Keeps a short shift history of one quantity and reports whether the new
// sample together with the history shows a firm rising or falling trend.
// ----------------------------------------------------------------------------
module ttfd_trend (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 push,
   input  wire logic signed [ttfd_pkg::HIST_W-1:0]   sample,
   output logic                                      firm
);

   logic signed [ttfd_pkg::HIST_W-1:0]      hist_ff [ttfd_pkg::HISTORY_DEPTH];
   logic        [ttfd_pkg::TREND_CNT_W-1:0] rises;
   logic        [ttfd_pkg::TREND_CNT_W-1:0] falls;
   logic signed [ttfd_pkg::HIST_W-1:0]      prev;

   always_comb begin
      rises = '0;
      falls = '0;
      prev  = sample;
      for (int k = 0; k < ttfd_pkg::HISTORY_DEPTH; k++) begin
         if (hist_ff[k] < prev) begin
            rises = rises + ttfd_pkg::TREND_CNT_W'(1);
         end else if (hist_ff[k] > prev) begin
            falls = falls + ttfd_pkg::TREND_CNT_W'(1);
         end
         prev = hist_ff[k];
      end
      if (rises >= falls) begin
         firm = (rises - falls) >= ttfd_pkg::TREND_FIRM;
      end else begin
         firm = (falls - rises) >= ttfd_pkg::TREND_FIRM;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ttfd_pkg::HISTORY_DEPTH; k++) begin
            hist_ff[k] <= ttfd_pkg::HIST_MIN
                          + ttfd_pkg::HIST_W'(ttfd_pkg::HISTORY_DEPTH - 1 - k);
         end
      end else if (push) begin
         hist_ff[0] <= sample;
         for (int k = 1; k < ttfd_pkg::HISTORY_DEPTH; k++) begin
            hist_ff[k] <= hist_ff[k-1];
         end
      end
   end

endmodule
`default_nettype wire

[design/thermal_trend_fan_duty_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Thermal trend fan duty controller
// Turns one tick of sensor temperatures and fan status into a fan duty.
// ----------------------------------------------------------------------------
// One request transaction is taken every cycle unless req_stall is high; its
// response is then held in the response register until taken. The request
// lands in an input register, and a
// single pass of logic (five-way sum, peak, trend compares, threshold picks,
// boost and cap) feeds the response register. The sum and peak histories and
// the held duty are updated as a transaction without a fan fault moves into the
// response register, so consecutive transactions see each other's effect. Settings
// writes are always accepted (csr_ready stays high) and take effect on the
// next cycle; they are meant to be issued only while no transaction is open.
module thermal_trend_fan_duty_controller (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [ttfd_pkg::TEMP_W-1:0]  req_temp_a,
   input  wire logic signed [ttfd_pkg::TEMP_W-1:0]  req_temp_b,
   input  wire logic signed [ttfd_pkg::TEMP_W-1:0]  req_temp_c,
   input  wire logic signed [ttfd_pkg::TEMP_W-1:0]  req_temp_d,
   input  wire logic signed [ttfd_pkg::TEMP_W-1:0]  req_temp_e,
   input  wire logic [ttfd_pkg::MASK_W-1:0]         req_fan_present_mask,
   input  wire logic [ttfd_pkg::MASK_W-1:0]         req_fan_failed_mask,
   input  wire logic                                req_airflow_back_to_front,
   input  wire logic [ttfd_pkg::DUTY_W-1:0]         req_current_duty,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [ttfd_pkg::DUTY_W-1:0]              rsp_duty_out,
   output logic                                     rsp_write_duty,
   output logic                                     rsp_fan_fault,

   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ttfd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [ttfd_pkg::CSR_DATA_W-1:0]     csr_data
);

   typedef struct packed {
      logic signed [ttfd_pkg::TEMP_W-1:0] temp_a;
      logic signed [ttfd_pkg::TEMP_W-1:0] temp_b;
      logic signed [ttfd_pkg::TEMP_W-1:0] temp_c;
      logic signed [ttfd_pkg::TEMP_W-1:0] temp_d;
      logic signed [ttfd_pkg::TEMP_W-1:0] temp_e;
      logic [ttfd_pkg::MASK_W-1:0]        present;
      logic [ttfd_pkg::MASK_W-1:0]        failed;
      logic                               back_to_front;
      logic [ttfd_pkg::DUTY_W-1:0]        current_duty;
   } req_type;

   ttfd_pkg::cfg_type cfg;

   req_type                      s1_ff;
   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [ttfd_pkg::DUTY_W-1:0]  rsp_duty_ff;
   logic [ttfd_pkg::DUTY_W-1:0]  rsp_duty_in;
   logic                         rsp_write_ff;
   logic                         rsp_write_in;
   logic                         rsp_fault_ff;
   logic                         rsp_fault_in;
   logic [ttfd_pkg::DUTY_W-1:0]  held_duty_ff;
   logic [ttfd_pkg::DUTY_W-1:0]  held_duty_in;

   logic                         load_s1;
   logic                         advance;
   logic                         fault;
   logic                         push;
   logic [ttfd_pkg::FAN_SCAN_W-1:0] present_x;
   logic [ttfd_pkg::FAN_SCAN_W-1:0] failed_x;

   logic signed [ttfd_pkg::TEMP_W-1:0] temps [ttfd_pkg::SENSOR_COUNT];
   logic signed [ttfd_pkg::SUM_W-1:0]  sum_raw;
   logic signed [ttfd_pkg::HIST_W-1:0] sum_sat;
   logic signed [ttfd_pkg::SUM_W-1:0]  sum_cmp;
   logic signed [ttfd_pkg::TEMP_W-1:0] peak_s;
   logic [ttfd_pkg::PEAK_W-1:0]        peak;
   logic signed [ttfd_pkg::HIST_W-1:0] peak_hist;
   logic                               avg_firm;
   logic                               peak_firm;

   logic [ttfd_pkg::DUTY_W-1:0]        avg_pick;
   logic [ttfd_pkg::DUTY_W-1:0]        peak_pick;
   logic [ttfd_pkg::DUTY_W-1:0]        pick;
   logic [ttfd_pkg::DUTY_W-1:0]        base_duty;
   logic [ttfd_pkg::DUTY_W:0]          boosted;
   logic [ttfd_pkg::DUTY_W-1:0]        final_duty;

   ttfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Handshake and pipeline control.
   assign advance      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = s1_valid_ff && !advance;
   assign load_s1      = req_valid && !req_stall;
   assign s1_valid_in  = load_s1 || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // Fan status.
   assign present_x = ttfd_pkg::FAN_SCAN_W'(s1_ff.present);
   assign failed_x  = ttfd_pkg::FAN_SCAN_W'(s1_ff.failed);
   assign fault     = |((~present_x | failed_x) & ttfd_pkg::FAN_SELECT);
   assign push      = advance && !fault;

   // Sum and peak of the sensor readings.
   assign temps[0] = s1_ff.temp_a;
   assign temps[1] = s1_ff.temp_b;
   assign temps[2] = s1_ff.temp_c;
   assign temps[3] = s1_ff.temp_d;
   assign temps[4] = s1_ff.temp_e;

   always_comb begin
      sum_raw = '0;
      peak_s  = '0;
      for (int k = 0; k < ttfd_pkg::SENSOR_COUNT; k++) begin
         sum_raw = sum_raw + ttfd_pkg::SUM_W'(temps[k]);
         if (temps[k] > peak_s) begin
            peak_s = temps[k];
         end
      end
      if (sum_raw > ttfd_pkg::SUM_W'(ttfd_pkg::HIST_MAX)) begin
         sum_sat = ttfd_pkg::HIST_MAX;
      end else if (sum_raw < ttfd_pkg::SUM_W'(ttfd_pkg::HIST_MIN)) begin
         sum_sat = ttfd_pkg::HIST_MIN;
      end else begin
         sum_sat = sum_raw[ttfd_pkg::HIST_W-1:0];
      end
   end

   assign sum_cmp   = ttfd_pkg::SUM_W'(sum_sat);
   assign peak      = peak_s[ttfd_pkg::PEAK_W-1:0];
   assign peak_hist = $signed(ttfd_pkg::HIST_W'(peak));

   ttfd_trend u_sum_trend (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .sample (sum_sat),
      .firm   (avg_firm)
   );

   ttfd_trend u_peak_trend (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .sample (peak_hist),
      .firm   (peak_firm)
   );

   // Threshold picks, hold, boost, cap and fault override.
   always_comb begin
      avg_pick = '0;
      if (avg_firm) begin
         if ($signed(sum_cmp) > $signed(cfg.avg_full_bound)) begin
            avg_pick = ttfd_pkg::DUTY_FULL;
         end else if ($signed(sum_cmp) > $signed(cfg.avg_mid_bound)) begin
            avg_pick = cfg.mid_duty;
         end
         if (!($signed(sum_cmp) > $signed(cfg.avg_low_bound))) begin
            avg_pick = cfg.low_duty;
         end
      end

      peak_pick = '0;
      if (peak_firm) begin
         if (peak > cfg.peak_full) begin
            peak_pick = ttfd_pkg::DUTY_FULL;
         end else if (peak > cfg.peak_mid) begin
            peak_pick = cfg.mid_duty;
         end
      end

      pick = (peak_pick > avg_pick) ? peak_pick : avg_pick;

      if (pick == '0) begin
         base_duty    = held_duty_ff;
         held_duty_in = held_duty_ff;
      end else begin
         base_duty    = pick;
         held_duty_in = pick;
      end

      if (s1_ff.back_to_front) begin
         boosted = {1'b0, base_duty} + {1'b0, cfg.reverse_boost};
      end else begin
         boosted = {1'b0, base_duty};
      end

      if (boosted > {1'b0, ttfd_pkg::DUTY_FULL}) begin
         final_duty = ttfd_pkg::DUTY_FULL;
      end else begin
         final_duty = boosted[ttfd_pkg::DUTY_W-1:0];
      end

      if (fault) begin
         rsp_duty_in  = ttfd_pkg::DUTY_FULL;
         rsp_write_in = 1'b1;
         rsp_fault_in = 1'b1;
      end else begin
         rsp_duty_in  = final_duty;
         rsp_write_in = final_duty != s1_ff.current_duty;
         rsp_fault_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_duty_ff <= ttfd_pkg::HELD_DUTY_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (push) begin
            held_duty_ff <= held_duty_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_ff.temp_a        <= req_temp_a;
         s1_ff.temp_b        <= req_temp_b;
         s1_ff.temp_c        <= req_temp_c;
         s1_ff.temp_d        <= req_temp_d;
         s1_ff.temp_e        <= req_temp_e;
         s1_ff.present       <= req_fan_present_mask;
         s1_ff.failed        <= req_fan_failed_mask;
         s1_ff.back_to_front <= req_airflow_back_to_front;
         s1_ff.current_duty  <= req_current_duty;
      end
      if (advance) begin
         rsp_duty_ff  <= rsp_duty_in;
         rsp_write_ff <= rsp_write_in;
         rsp_fault_ff <= rsp_fault_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_duty_out   = rsp_duty_ff;
   assign rsp_write_duty = rsp_write_ff;
   assign rsp_fan_fault  = rsp_fault_ff;

endmodule
`default_nettype wire

[design/ttfd_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker
// Watches the controller's ports for handshake and response rules that must always hold.
// ----------------------------------------------------------------------------
module ttfd_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic [ttfd_pkg::DUTY_W-1:0]         rsp_duty_out,
   input wire logic                                rsp_write_duty,
   input wire logic                                rsp_fan_fault
);

   // A fan fault always orders a full duty write.
   fault_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fan_fault |-> rsp_duty_out == ttfd_pkg::DUTY_FULL && rsp_write_duty)
      else $error("fan fault response without full duty write");

   duty_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty_out <= ttfd_pkg::DUTY_FULL)
      else $error("response duty above full");

   // No response may be valid right after reset is released.
   rsp_needs_req: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_duty_out)
                                 && $stable(rsp_write_duty) && $stable(rsp_fan_fault))
      else $error("stalled response changed");

   req_stall_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall || !$past(req_valid))
      else $error("request stalled while the response side is empty");

endmodule

bind thermal_trend_fan_duty_controller ttfd_checker u_ttfd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_duty_out   (rsp_duty_out),
   .rsp_write_duty (rsp_write_duty),
   .rsp_fan_fault  (rsp_fan_fault)
);
`default_nettype wire
